@@ sv/sustained_note_table_macros.svh @@
// Assertion helpers for the sustained note table
`ifndef SUSTAINED_NOTE_TABLE_MACROS_SVH
`define SUSTAINED_NOTE_TABLE_MACROS_SVH

// clocked check, held off during reset
`define SNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication shorthand
`define SNT_IMPLIES(lbl, ante, cons, msg) \
  `SNT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ sv/snt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snt_pkg
// Shared codes and controller/datapath types for the sustained note table.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  localparam logic [16:0] ONE_SECOND = 17'd65536;
  localparam logic [15:0] THRESH_RESET = 16'd66;

  localparam logic RD_IDX  = 1'b0;
  localparam logic RD_LAST = 1'b1;

  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_APPEND = 3'd1;
  localparam logic [2:0] WR_SETT   = 3'd2;
  localparam logic [2:0] WR_KEEP   = 3'd3;
  localparam logic [2:0] WR_MOVE   = 3'd4;
  localparam logic [2:0] WR_WB     = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic       rd_sel;
    logic [2:0] wr_op;
    logic       idx_inc;
    logic       cnt_dec;
    logic       save_tmp;
    logic       ovf_set;
    logic       scan_init;
    logic       soon_upd;
    logic       ld_rem;
    logic       ld_sum;
  } ctl_cmd_t;

  typedef struct packed {
    logic at_cnt;
    logic at_end;
    logic match;
    logic gone;
    logic full;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

@@ sv/snt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snt_req_if / snt_rsp_if
// Command and result channels, valid/ready transfer.
// ----------------------------------------------------------------------------
interface snt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  in_chan;
  logic [7:0]  in_note;
  logic [23:0] duration;
  logic [23:0] elapsed;
  logic [15:0] drop_mask;
  modport source (output valid, cmd, in_chan, in_note, duration, elapsed, drop_mask,
                  input ready);
  modport sink (input valid, cmd, in_chan, in_note, duration, elapsed, drop_mask,
                output ready);
endinterface

interface snt_rsp_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [3:0]  out_chan;
  logic [7:0]  out_note;
  logic [23:0] out_remaining;
  logic [16:0] soonest;
  logic [5:0]  held_count;
  logic        overflow;
  logic        last;
  modport source (output valid, is_summary, out_chan, out_note, out_remaining, soonest,
                  held_count, overflow, last, input ready);
  modport sink (input valid, is_summary, out_chan, out_note, out_remaining, soonest,
                held_count, overflow, last, output ready);
endinterface
`default_nettype wire

@@ sv/sustained_note_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an input transfer leads to the summary after the compare or eviction scan, a
//   scan of the K kept notes, and emission of the R removed notes in slot order; output
//   stalls hold the sequence.
// Commands are taken one at a time; the next command is taken the cycle after the summary
//   is loaded.
// Reset (rst, synchronous): table empty, threshold 66, no pending result; no clearing pass.
// ----------------------------------------------------------------------------
// sustained_note_table
// Held-note table with add, advance, remove-by-channel, clear and query.
// ----------------------------------------------------------------------------
`include "sustained_note_table_macros.svh"

module sustained_note_table #(
  parameter int DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  snt_req_if.sink          req,
  snt_rsp_if.source        rsp
);

  logic [15:0]       thresh;
  snt_pkg::ctl_cmd_t ctl;
  snt_pkg::ctl_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, thresh} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= snt_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      thresh <= pwdata[15:0];
    end
  end

  snt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  snt_dp #(.DEPTH(DEPTH)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sts    (sts),
    .thresh (thresh),
    .req    (req),
    .rsp    (rsp)
  );

  `SNT_IMPLIES(a_held_le_depth, rsp.valid && rsp.is_summary, rsp.held_count <= DEPTH, "held count above depth")
  `SNT_IMPLIES(a_ovf_summary, rsp.valid && rsp.overflow, rsp.is_summary, "overflow on removed note")
  `SNT_IMPLIES(a_soon_cap, rsp.valid, rsp.soonest <= snt_pkg::ONE_SECOND, "soonest above cap")
  `SNT_IMPLIES(a_ready_idle, rsp.valid && !rsp.is_summary, !req.ready, "taking command mid-emit")

endmodule
`default_nettype wire

@@ sv/snt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snt_ctrl
// Command sequencer: table scan, swap eviction, min scan, result emission.
// ----------------------------------------------------------------------------
module snt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [2:0]        req_cmd,
  output logic                   req_ready,
  input  wire snt_pkg::ctl_sts_t sts,
  output snt_pkg::ctl_cmd_t      ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] A_RD    = 4'd1;
  localparam logic [3:0] A_EX    = 4'd2;
  localparam logic [3:0] A_EMIT  = 4'd3;
  localparam logic [3:0] V_RD    = 4'd4;
  localparam logic [3:0] V_EX    = 4'd5;
  localparam logic [3:0] V_MV    = 4'd6;
  localparam logic [3:0] V_WB    = 4'd7;
  localparam logic [3:0] M_START = 4'd8;
  localparam logic [3:0] M_RD    = 4'd9;
  localparam logic [3:0] M_EX    = 4'd10;
  localparam logic [3:0] E_RD    = 4'd11;
  localparam logic [3:0] E_EX    = 4'd12;
  localparam logic [3:0] S_SUM   = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.wr_op = snt_pkg::WR_NONE;
    ctl.rd_sel = snt_pkg::RD_IDX;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.accept = 1'b1;
          unique case (req_cmd) inside
            snt_pkg::CMD_ADD: state_next = A_RD;
            snt_pkg::CMD_ADVANCE, snt_pkg::CMD_REMOVE: state_next = V_RD;
            default: state_next = M_START;
          endcase
        end
      end
      A_RD: begin
        if (sts.at_cnt) begin
          if (sts.full) begin
            ctl.ovf_set = 1'b1;
          end else begin
            ctl.wr_op = snt_pkg::WR_APPEND;
          end
          state_next = M_START;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = A_EX;
        end
      end
      A_EX: begin
        if (sts.match) begin
          state_next = A_EMIT;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next = A_RD;
        end
      end
      A_EMIT: begin
        if (sts.out_free) begin
          ctl.ld_rem = 1'b1;
          ctl.wr_op = snt_pkg::WR_SETT;
          state_next = M_START;
        end
      end
      V_RD: begin
        if (sts.at_cnt) begin
          state_next = M_START;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = V_EX;
        end
      end
      V_EX: begin
        if (sts.gone) begin
          ctl.save_tmp = 1'b1;
          ctl.cnt_dec = 1'b1;
          ctl.rd_en = 1'b1;
          ctl.rd_sel = snt_pkg::RD_LAST;
          state_next = V_MV;
        end else begin
          ctl.wr_op = snt_pkg::WR_KEEP;
          ctl.idx_inc = 1'b1;
          state_next = V_RD;
        end
      end
      V_MV: begin
        ctl.wr_op = snt_pkg::WR_MOVE;
        state_next = V_WB;
      end
      V_WB: begin
        ctl.wr_op = snt_pkg::WR_WB;
        state_next = V_RD;
      end
      M_START: begin
        ctl.scan_init = 1'b1;
        state_next = M_RD;
      end
      M_RD: begin
        if (sts.at_cnt) begin
          state_next = E_RD;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = M_EX;
        end
      end
      M_EX: begin
        ctl.soon_upd = 1'b1;
        ctl.idx_inc = 1'b1;
        state_next = M_RD;
      end
      E_RD: begin
        if (sts.at_end) begin
          state_next = S_SUM;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = E_EX;
        end
      end
      E_EX: begin
        if (sts.out_free) begin
          ctl.ld_rem = 1'b1;
          ctl.idx_inc = 1'b1;
          state_next = E_RD;
        end
      end
      S_SUM: begin
        if (sts.out_free) begin
          ctl.ld_sum = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/snt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snt_dp
// Note table memory, counters, soonest tracker and result register.
// ----------------------------------------------------------------------------
module snt_dp #(
  parameter int DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire snt_pkg::ctl_cmd_t ctl,
  output snt_pkg::ctl_sts_t      sts,
  input  wire logic [15:0]       thresh,
  snt_req_if.sink                req,
  snt_rsp_if.source              rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [35:0]   mem [DEPTH];
  logic [35:0]   rdata;
  logic [CW-1:0] cnt, old_cnt, idx;
  logic [11:0]   key_l;
  logic [23:0]   dur_l, delta_l;
  logic [15:0]   mask_l;
  logic          is_adv;
  logic [11:0]   tmp_key;
  logic [23:0]   tmp_t;
  logic [16:0]   soon;
  logic          ovf;

  logic [11:0]   rkey;
  logic [23:0]   rtime, tsub, t_keep;
  logic          gone;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] raddr, waddr;
  logic [35:0]   wdata;
  logic          we;
  logic          out_free;

  assign rkey   = rdata[35:24];
  assign rtime  = rdata[23:0];
  assign tsub   = (rtime > delta_l) ? (rtime - delta_l) : 24'd0;
  assign t_keep = is_adv ? tsub : rtime;
  assign gone   = is_adv ? (tsub <= {8'd0, thresh}) : mask_l[rkey[11:8]];
  assign cnt_m1 = cnt - CW'(1);
  assign raddr  = (ctl.rd_sel == snt_pkg::RD_LAST) ? cnt_m1[AW-1:0] : idx[AW-1:0];
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    we = 1'b1;
    waddr = idx[AW-1:0];
    wdata = rdata;
    case (ctl.wr_op)
      snt_pkg::WR_APPEND: begin
        waddr = cnt[AW-1:0];
        wdata = {key_l, dur_l};
      end
      snt_pkg::WR_SETT: wdata = {rkey, dur_l};
      snt_pkg::WR_KEEP: wdata = {rkey, t_keep};
      snt_pkg::WR_MOVE: wdata = rdata;
      snt_pkg::WR_WB: begin
        waddr = cnt[AW-1:0];
        wdata = {tmp_key, tmp_t};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      old_cnt <= '0;
      idx <= '0;
      ovf <= 1'b0;
    end else begin
      if (ctl.accept) begin
        idx <= '0;
        ovf <= 1'b0;
        if (req.cmd == snt_pkg::CMD_CLEAR) begin
          cnt <= '0;
          old_cnt <= '0;
        end else begin
          old_cnt <= cnt;
        end
      end
      if (ctl.wr_op == snt_pkg::WR_APPEND) begin
        cnt <= cnt + CW'(1);
      end
      if (ctl.cnt_dec) begin
        cnt <= cnt_m1;
      end
      if (ctl.ovf_set) begin
        ovf <= 1'b1;
      end
      if (ctl.scan_init) begin
        idx <= '0;
      end
      if (ctl.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      key_l   <= {req.in_chan, req.in_note};
      dur_l   <= req.duration;
      delta_l <= req.elapsed;
      mask_l  <= req.drop_mask;
      is_adv  <= (req.cmd == snt_pkg::CMD_ADVANCE);
    end
    if (ctl.save_tmp) begin
      tmp_key <= rkey;
      tmp_t   <= t_keep;
    end
    if (ctl.scan_init) begin
      soon <= snt_pkg::ONE_SECOND;
    end else if (ctl.soon_upd && (rtime < {7'd0, soon})) begin
      soon <= rtime[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctl.ld_rem || ctl.ld_sum) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_rem) begin
      rsp.is_summary    <= 1'b0;
      rsp.out_chan      <= rkey[11:8];
      rsp.out_note      <= rkey[7:0];
      rsp.out_remaining <= rtime;
      rsp.soonest       <= '0;
      rsp.held_count    <= '0;
      rsp.overflow      <= 1'b0;
      rsp.last          <= 1'b0;
    end else if (ctl.ld_sum) begin
      rsp.is_summary    <= 1'b1;
      rsp.out_chan      <= '0;
      rsp.out_note      <= '0;
      rsp.out_remaining <= '0;
      rsp.soonest       <= soon;
      rsp.held_count    <= 6'(cnt);
      rsp.overflow      <= ovf;
      rsp.last          <= 1'b1;
    end
  end

  assign sts.at_cnt   = (idx == cnt);
  assign sts.at_end   = (idx >= old_cnt);
  assign sts.match    = (rkey == key_l);
  assign sts.gone     = gone;
  assign sts.full     = (cnt == CW'(DEPTH));
  assign sts.out_free = out_free;

endmodule
`default_nettype wire

@@ verif/sustained_note_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sustained_note_table_tb
// Drives note commands into the held-note table and checks every removed
// note and summary transfer against a behavioral table kept in the bench.
// Random sender bursts, receiver stalls, one long receiver hold-off, and
// threshold changes between phases.
// ----------------------------------------------------------------------------
module sustained_note_table_tb;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  chan;
    logic [7:0]  note;
    logic [23:0] duration;
    logic [23:0] delta;
    logic [15:0] mask;
  } note_cmd_t;

  typedef struct packed {
    logic        is_summary;
    logic [3:0]  chan;
    logic [7:0]  note;
    logic [23:0] remaining;
    logic [16:0] soonest;
    logic [5:0]  held;
    logic        overflow;
    logic        last;
  } note_evt_t;

  localparam int DEPTH = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  snt_req_if req ();
  snt_rsp_if rsp ();

  sustained_note_table #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the table
  logic [11:0] tbl_key [DEPTH];
  logic [23:0] tbl_time [DEPTH];
  int unsigned tbl_count;
  logic [15:0] threshold;

  note_cmd_t pending_cmds[$];
  note_evt_t expected_evts[$];
  int errors;
  bit hold_off;
  bit sending;

  function automatic note_evt_t removed_evt(logic [11:0] k, logic [23:0] t);
    note_evt_t e;
    e = '0;
    e.chan = k[11:8];
    e.note = k[7:0];
    e.remaining = t;
    return e;
  endfunction

  task automatic apply_command(note_cmd_t c);
    int unsigned cnt, old_cnt, i;
    logic [11:0] k, kk;
    logic [23:0] t;
    logic [16:0] soon;
    bit found, gone, ovf;
    note_evt_t s;
    cnt = tbl_count;
    old_cnt = cnt;
    ovf = 0;
    k = {c.chan, c.note};
    if (c.cmd == snt_pkg::CMD_ADD) begin
      found = 0;
      for (i = 0; i < cnt; i++) begin
        if (!found && tbl_key[i] == k) begin
          expected_evts.push_back(removed_evt(tbl_key[i], tbl_time[i]));
          tbl_time[i] = c.duration;
          found = 1;
        end
      end
      if (!found) begin
        if (cnt < DEPTH) begin
          tbl_key[cnt] = k;
          tbl_time[cnt] = c.duration;
          cnt++;
        end else begin
          ovf = 1;
        end
      end
      tbl_count = cnt;
    end else if (c.cmd == snt_pkg::CMD_ADVANCE || c.cmd == snt_pkg::CMD_REMOVE) begin
      i = 0;
      while (i < cnt) begin
        t = tbl_time[i];
        if (c.cmd == snt_pkg::CMD_ADVANCE) begin
          t = (t > c.delta) ? t - c.delta : 24'd0;
          gone = (t <= {8'd0, threshold});
        end else begin
          gone = c.mask[tbl_key[i][11:8]];
        end
        if (gone) begin
          kk = tbl_key[i];
          cnt--;
          tbl_key[i] = tbl_key[cnt];
          tbl_time[i] = tbl_time[cnt];
          tbl_key[cnt] = kk;
          tbl_time[cnt] = t;
        end else begin
          tbl_time[i] = t;
          i++;
        end
      end
      for (i = cnt; i < old_cnt; i++)
        expected_evts.push_back(removed_evt(tbl_key[i], tbl_time[i]));
      tbl_count = cnt;
    end else if (c.cmd == snt_pkg::CMD_CLEAR) begin
      tbl_count = 0;
    end
    soon = snt_pkg::ONE_SECOND;
    for (i = 0; i < tbl_count; i++)
      if ({1'b0, tbl_time[i]} < {8'd0, soon}) soon = tbl_time[i][16:0];
    s = '0;
    s.is_summary = 1'b1;
    s.soonest = soon;
    s.held = tbl_count[5:0];
    s.overflow = ovf;
    s.last = 1'b1;
    expected_evts.push_back(s);
  endtask

  // driver: bursts and gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req.valid && req.ready) apply_command(pending_cmds.pop_front());
      if (req.valid && !req.ready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        req.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sending && pending_cmds.size() > 0) begin
        note_cmd_t c;
        c = pending_cmds[0];
        req.valid <= 1'b1;
        req.cmd <= c.cmd;
        req.in_chan <= c.chan;
        req.in_note <= c.note;
        req.duration <= c.duration;
        req.elapsed <= c.delta;
        req.drop_mask <= c.mask;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and monitor
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        note_evt_t a, e;
        a = {rsp.is_summary, rsp.out_chan, rsp.out_note, rsp.out_remaining,
             rsp.soonest, rsp.held_count, rsp.overflow, rsp.last};
        if (expected_evts.size() == 0) begin
          $error("unexpected transfer %h", a);
          errors++;
        end else begin
          e = expected_evts.pop_front();
          if (a.is_summary !== e.is_summary) begin
            $error("is_summary exp %0d got %0d", e.is_summary, a.is_summary); errors++;
          end
          if (a.chan !== e.chan) begin
            $error("out_chan exp %0d got %0d", e.chan, a.chan); errors++;
          end
          if (a.note !== e.note) begin
            $error("out_note exp %0d got %0d", e.note, a.note); errors++;
          end
          if (a.remaining !== e.remaining) begin
            $error("out_remaining exp %0d got %0d", e.remaining, a.remaining); errors++;
          end
          if (a.soonest !== e.soonest) begin
            $error("soonest exp %0d got %0d", e.soonest, a.soonest); errors++;
          end
          if (a.held !== e.held) begin
            $error("held_count exp %0d got %0d", e.held, a.held); errors++;
          end
          if (a.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, a.overflow); errors++;
          end
          if (a.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, a.last); errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_off) rsp.ready <= 1'b0;
      else case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic reg_write(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    threshold = v;
  endtask

  task automatic push(logic [2:0] c, logic [3:0] ch, logic [7:0] n, logic [23:0] d,
                      logic [23:0] dt, logic [15:0] m);
    pending_cmds.push_back({c, ch, n, d, dt, m});
  endtask

  task automatic settle;
    while (pending_cmds.size() > 0 || req.valid || expected_evts.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int j, r;
    logic [3:0] ch;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      ch = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      if (r < 50)
        push(snt_pkg::CMD_ADD, ch,
             ($urandom_range(0, 1) == 0) ? 8'($urandom_range(60, 67)) : 8'($urandom),
             ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000)),
             24'($urandom), 16'($urandom));
      else if (r < 75)
        push(snt_pkg::CMD_ADVANCE, 4'($urandom), 8'($urandom), 24'($urandom),
             ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 30000)),
             16'($urandom));
      else if (r < 85)
        push(snt_pkg::CMD_REMOVE, 4'($urandom), 8'($urandom), 24'($urandom),
             24'($urandom), 16'(1 << $urandom_range(0, 15))
             | (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0));
      else if (r < 88)
        push(snt_pkg::CMD_CLEAR, 4'($urandom), 8'($urandom), 24'($urandom),
             24'($urandom), 16'($urandom));
      else
        push(3'($urandom_range(4, 7)), 4'($urandom), 8'($urandom), 24'($urandom),
             24'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int j;
    errors = 0;
    tbl_count = 0;
    threshold = snt_pkg::THRESH_RESET;
    hold_off = 0;
    sending = 0;
    req.valid = 1'b0; req.cmd = '0; req.in_chan = '0; req.in_note = '0;
    req.duration = '0; req.elapsed = '0; req.drop_mask = '0;
    rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    push(snt_pkg::CMD_QUERY, 0, 0, 0, 0, 0);
    push(snt_pkg::CMD_ADD, 4'hF, 8'hFF, 24'hFFFFFF, 0, 0);
    push(snt_pkg::CMD_ADD, 0, 0, 0, 0, 0);
    push(snt_pkg::CMD_ADD, 4'hF, 8'hFF, 24'd100, 0, 0);
    push(snt_pkg::CMD_ADD, 4'h5, 8'h3C, 24'd66, 0, 0);
    push(snt_pkg::CMD_ADD, 4'h5, 8'h3D, 24'd67, 0, 0);
    push(snt_pkg::CMD_ADVANCE, 0, 0, 0, 24'd0, 0);
    push(snt_pkg::CMD_ADVANCE, 0, 0, 0, 24'd1, 0);
    push(snt_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h8000);
    push(snt_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'h0000);
    push(3'd5, 0, 0, 0, 0, 0);
    push(3'd7, 0, 0, 0, 0, 0);
    push(snt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    push(snt_pkg::CMD_ADVANCE, 0, 0, 0, 24'hFFFFFF, 16'hFFFF);
    for (j = 0; j < 34; j++)
      push(snt_pkg::CMD_ADD, 4'(j), 8'(j * 7), 24'(1000 + j), 0, 0);
    push(snt_pkg::CMD_ADVANCE, 0, 0, 0, 24'hFFFFFF, 0);
    sending = 1;
    settle();

    // queue adds past the table depth while the receiver is held off
    for (j = 0; j < 40; j++)
      push(snt_pkg::CMD_ADD, 4'($urandom), 8'($urandom), 24'($urandom_range(0, 90000)), 0, 0);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
    push(snt_pkg::CMD_REMOVE, 0, 0, 0, 0, 16'hFFFF);
    random_phase(100);
    settle();

    reg_write(16'd0);
    random_phase(70);
    settle();
    reg_write(16'hFFFF);
    random_phase(50);
    settle();
    reg_write(16'd500);
    random_phase(70);
    settle();

    if (errors == 0) $display("sustained_note_table_tb: done, clean");
    else $display("sustained_note_table_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("sustained_note_table_tb: done, errors");
    $finish;
  end
endmodule
